// ===== src/dsi_pkg.sv =====
// Package for the discrete Sibson interpolator: sizes, codes, command and
// status structures shared by the controller, the datapath and the top level.
// Depends on nothing.
package dsi_pkg;

  localparam int MAX_NODES  = 256;
  localparam int MAX_AXIS   = 16;
  localparam int NODE_AW    = $clog2(MAX_NODES);
  localparam int NODE_CW    = NODE_AW + 1;
  localparam int AXIS_W     = $clog2(MAX_AXIS);
  localparam int SIZE_W     = 5;
  localparam int CELLS      = MAX_AXIS * MAX_AXIS * MAX_AXIS;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int CNT_W      = CELL_W + 1;
  localparam int Q_FRAC     = 4;
  localparam int COORD_W    = AXIS_W + Q_FRAC;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 45;
  localparam int DIFF_W     = COORD_W + 2;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = SQ_W + 2;
  localparam int RAD_SHIFT  = 2 * Q_FRAC;
  localparam int NODE_W     = 3 * COORD_W + VAL_W;
  localparam int GRID_W     = SUM_W + CNT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  localparam logic RES_RUN  = 1'b0;
  localparam logic RES_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD1,
    S_RD2,
    S_DIV,
    S_SRCH,
    S_LCALC,
    S_ACC,
    S_FIN
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic srch_en;
    logic lcalc_en;
    logic acc_en;
    logic rd_cap;
    logic cell_next;
    logic fin_load;
    logic idle;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic total_zero;
    logic srch_done;
    logic l_done;
    logic acc_last;
    logic cell_last;
    logic div_busy;
    logic out_free;
  } sts_t;

  // Zero means one cell; anything above the grid limit saturates.
  function automatic logic [SIZE_W-1:0] axis_len(input logic [SIZE_W-1:0] r);
    logic [SIZE_W-1:0] n;
    if (r == '0) begin
      n = SIZE_W'(1);
    end else if (r > SIZE_W'(MAX_AXIS)) begin
      n = SIZE_W'(MAX_AXIS);
    end else begin
      n = r;
    end
    return n;
  endfunction

endpackage

// ===== src/dsi_if.sv =====
// Channel interfaces of the discrete Sibson interpolator: the input word and
// the result word, each with a valid/ready handshake. Depends on nothing.
interface dsi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        first_node;
  logic [7:0]  node_x;
  logic [7:0]  node_y;
  logic [7:0]  node_z;
  logic signed [31:0] node_value;
  logic [11:0] cell_index;

  modport source (output valid, kind, first_node, node_x, node_y, node_z, node_value,
                  cell_index, input ready);
  modport sink (input valid, kind, first_node, node_x, node_y, node_z, node_value,
                cell_index, output ready);
endinterface

interface dsi_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic signed [31:0] cell_value;
  logic [12:0] contributor_count;
  logic [8:0]  nodes_used;

  modport source (output valid, result_kind, cell_value, contributor_count, nodes_used,
                  input ready);
  modport sink (input valid, result_kind, cell_value, contributor_count, nodes_used,
                output ready);
endinterface

// ===== src/discrete_sibson_interpolator_top.sv =====
// Top level of the discrete Sibson interpolator: the input and result
// channels, the configuration port, the controller and the datapath.
// Depends on dsi_pkg, dsi_if, dsi_ctrl and dsi_dp.
//
// Each input word is a node load, a run or a cell read. A load is taken with the
// handshake and gives no result; loads can follow each other in every cycle. A run
// clears the whole 4096-cell grid, then, if any nodes are loaded, for every grid cell
// searches all loaded nodes, grows the window radius step by step up to at most 15
// and walks the clipped window one cell per cycle, a read-modify-write on the grid
// memory. The run result follows at the end.
// A read runs through the 45-step bit-serial divider.
// The input is not ready while a run or read is at work. A finished result
// sits in an output register, so the next word is taken while it waits; a
// new run or read that finishes holds there until the receiver takes the
// earlier word. After reset the grid memory is cleared in one full pass
// with the input not ready. Configuration writes take effect at once,
// so they belong between words, while no run or read is at work.
module discrete_sibson_interpolator_top import dsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dsi_in_if.sink               in_i,
  dsi_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  // A word is taken on a valid and ready edge.
  assign in_fire = in_i.valid && in_i.ready;

  dsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_kind_i  (in_i.kind),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_i.ready)
  );

  dsi_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .in_fire_i           (in_fire),
    .kind_i              (in_i.kind),
    .first_node_i        (in_i.first_node),
    .node_x_i            (in_i.node_x),
    .node_y_i            (in_i.node_y),
    .node_z_i            (in_i.node_z),
    .node_value_i        (in_i.node_value),
    .cell_index_i        (in_i.cell_index),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .out_ready_i         (out_o.ready),
    .out_valid_o         (out_o.valid),
    .result_kind_o       (out_o.result_kind),
    .cell_value_o        (out_o.cell_value),
    .contributor_count_o (out_o.contributor_count),
    .nodes_used_o        (out_o.nodes_used)
  );

`ifndef NO_ASSERTIONS
  // A new result only appears after the controller loaded the result register.
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.fin_load))
    else $error("result appeared without a finish load");

  // The input stays closed while a window is being accumulated.
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.acc_en |-> !in_i.ready)
    else $error("input ready during window accumulation");

  // A node search is never started with an empty node list.
  a_search_has_nodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.srch_en |-> !sts.total_zero)
    else $error("node search with no nodes");
`endif

endmodule

// ===== src/dsi_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. Depends on nothing.
module dsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dsi_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on dsi_pkg.
module dsi_div import dsi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [SUM_W-1:0] quotient_o
);

  logic                  busy_q, busy_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]      quo_q, quo_d;
  logic [CNT_W:0]        rem_q, rem_d;
  logic [CNT_W-1:0]      dvs_q, dvs_d;
  logic [CNT_W:0]        shifted;
  logic                  ge;

  assign shifted = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? (shifted - {1'b0, dvs_q}) : shifted;
      quo_d  = {quo_q[SUM_W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == DIV_STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/dsi_ctrl.sv =====
// Controller state machine of the interpolator: sequences clearing, node
// search, radius search, window accumulation and cell reads. Depends on dsi_pkg.
module dsi_ctrl import dsi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic [1:0] in_kind_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       in_ready_o
);

  state_e state_q, state_d;
  logic   run_q, run_d;

  always_comb begin
    state_d = state_q;
    run_d   = run_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_done) begin
          run_d = 1'b0;
          if (!run_q) begin
            state_d = S_IDLE;
          end else if (sts_i.total_zero) begin
            state_d = S_FIN;
          end else begin
            state_d = S_SRCH;
          end
        end
      end
      S_IDLE: begin
        if (in_fire_i && in_kind_i == KIND_RUN) begin
          run_d   = 1'b1;
          state_d = S_CLEAR;
        end else if (in_fire_i && in_kind_i == KIND_READ) begin
          state_d = S_RD1;
        end
      end
      S_RD1:   state_d = S_RD2;
      S_RD2:   state_d = S_DIV;
      S_DIV: begin
        if (!sts_i.div_busy) state_d = S_FIN;
      end
      S_SRCH: begin
        if (sts_i.srch_done) state_d = S_LCALC;
      end
      S_LCALC: begin
        if (sts_i.l_done) state_d = S_ACC;
      end
      S_ACC: begin
        if (sts_i.acc_last) state_d = sts_i.cell_last ? S_FIN : S_SRCH;
      end
      S_FIN: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_CLEAR: cmd_o.clr_en = 1'b1;
      S_IDLE:  cmd_o.idle = 1'b1;
      S_RD2:   cmd_o.rd_cap = 1'b1;
      S_SRCH:  cmd_o.srch_en = 1'b1;
      S_LCALC: cmd_o.lcalc_en = 1'b1;
      S_ACC: begin
        cmd_o.acc_en    = 1'b1;
        cmd_o.cell_next = sts_i.acc_last && !sts_i.cell_last;
      end
      S_FIN:   cmd_o.fin_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  assign in_ready_o = cmd_o.idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      run_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      run_q   <= run_d;
    end
  end

endmodule

// ===== src/dsi_dp.sv =====
// Datapath of the interpolator: configuration, node and grid memories,
// sweep counters, distance arithmetic, divider and result register.
// Depends on dsi_pkg, dsi_ram and dsi_div.
module dsi_dp import dsi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  in_fire_i,
  input  logic [1:0]            kind_i,
  input  logic                  first_node_i,
  input  logic [COORD_W-1:0]    node_x_i,
  input  logic [COORD_W-1:0]    node_y_i,
  input  logic [COORD_W-1:0]    node_z_i,
  input  logic signed [VAL_W-1:0] node_value_i,
  input  logic [CELL_W-1:0]     cell_index_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [SIZE_W-1:0]     cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  result_kind_o,
  output logic signed [VAL_W-1:0] cell_value_o,
  output logic [CNT_W-1:0]      contributor_count_o,
  output logic [NODE_CW-1:0]    nodes_used_o
);

  // Configuration.
  logic [SIZE_W-1:0] gx_q, gy_q, gz_q;
  logic [SIZE_W-1:0] sx, sy, sz;
  logic [AXIS_W-1:0] sx_m1, sy_m1, sz_m1;
  logic [2*SIZE_W-1:0] sxy;
  logic [CNT_W-1:0]  n_cells;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q <= SIZE_W'(MAX_AXIS);
      gy_q <= SIZE_W'(MAX_AXIS);
      gz_q <= SIZE_W'(MAX_AXIS);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_X: gx_q <= cfg_data_i;
        REG_GRID_Y: gy_q <= cfg_data_i;
        REG_GRID_Z: gz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sx      = axis_len(gx_q);
  assign sy      = axis_len(gy_q);
  assign sz      = axis_len(gz_q);
  assign sx_m1   = AXIS_W'(sx - SIZE_W'(1));
  assign sy_m1   = AXIS_W'(sy - SIZE_W'(1));
  assign sz_m1   = AXIS_W'(sz - SIZE_W'(1));
  assign sxy     = sx * sy;
  assign n_cells = CNT_W'(sxy * sz);

  // Node store and node count.
  logic [NODE_CW-1:0] tot_q;
  logic               load, full, node_we;
  logic [NODE_AW-1:0] node_waddr;
  logic [NODE_W-1:0]  node_rdata;
  logic [NODE_CW-1:0] m_q;
  logic               issue;

  assign load       = in_fire_i && kind_i == KIND_LOAD;
  assign full       = tot_q == NODE_CW'(MAX_NODES);
  assign node_we    = load && (first_node_i || !full);
  assign node_waddr = first_node_i ? '0 : tot_q[NODE_AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
    end else if (node_we) begin
      tot_q <= first_node_i ? NODE_CW'(1) : tot_q + 1'b1;
    end
  end

  dsi_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i ({node_x_i, node_y_i, node_z_i, node_value_i}),
    .raddr_i (m_q[NODE_AW-1:0]),
    .rdata_o (node_rdata)
  );

  // Sweep cell counters.
  logic [AXIS_W-1:0] ci_q, cj_q, ck_q;
  logic              cell_last;

  assign cell_last = ci_q == sx_m1 && cj_q == sy_m1 && ck_q == sz_m1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      ci_q <= '0;
      cj_q <= '0;
      ck_q <= '0;
    end else if (cmd_i.cell_next) begin
      if (ci_q != sx_m1) begin
        ci_q <= ci_q + 1'b1;
      end else begin
        ci_q <= '0;
        if (cj_q != sy_m1) begin
          cj_q <= cj_q + 1'b1;
        end else begin
          cj_q <= '0;
          ck_q <= ck_q + 1'b1;
        end
      end
    end
  end

  // Nearest node search, one node per cycle through the registered read.
  logic                     sv_q, sfirst_q;
  logic [DIST_W-1:0]        best_q, t_dist;
  logic signed [VAL_W-1:0]  f_q;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [2*DIFF_W-1:0] px, py, pz;

  assign issue = cmd_i.srch_en && (m_q < tot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q  <= '0;
      sv_q <= 1'b0;
    end else begin
      m_q  <= cmd_i.srch_en ? (issue ? m_q + 1'b1 : m_q) : '0;
      sv_q <= issue;
    end
  end

  assign dx = $signed({2'b00, ci_q, {Q_FRAC{1'b0}}})
            - $signed({2'b00, node_rdata[NODE_W-1 -: COORD_W]});
  assign dy = $signed({2'b00, cj_q, {Q_FRAC{1'b0}}})
            - $signed({2'b00, node_rdata[NODE_W-1-COORD_W -: COORD_W]});
  assign dz = $signed({2'b00, ck_q, {Q_FRAC{1'b0}}})
            - $signed({2'b00, node_rdata[VAL_W+COORD_W-1 -: COORD_W]});
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;
  assign t_dist = DIST_W'(px[SQ_W-1:0]) + DIST_W'(py[SQ_W-1:0]) + DIST_W'(pz[SQ_W-1:0]);

  always_ff @(posedge clk_i) begin
    sfirst_q <= issue && m_q == '0;
    if (sv_q && (sfirst_q || t_dist < best_q)) begin
      best_q <= t_dist;
      f_q    <= $signed(node_rdata[VAL_W-1:0]);
    end
  end

  // Window radius: largest l, at most 15, with l^2 cells squared still inside. It is
  // cleared during the node search and held through the window walk.
  logic [AXIS_W-1:0]   l_q;
  logic [AXIS_W:0]     lp1;
  logic [2*AXIS_W+1:0] lsq;
  logic [DIST_W-1:0]   rad2;
  logic                grow;

  assign rad2 = best_q >> RAD_SHIFT;
  assign lp1  = {1'b0, l_q} + 1'b1;
  assign lsq  = lp1 * lp1;
  assign grow = (l_q != AXIS_W'(MAX_AXIS - 1)) && (DIST_W'(lsq) <= rad2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.lcalc_en) begin
      l_q <= grow ? l_q + 1'b1 : l_q;
    end else if (cmd_i.srch_en) begin
      l_q <= '0;
    end
  end

  function automatic logic [AXIS_W-1:0] win_lo(input logic [AXIS_W-1:0] c,
                                               input logic [AXIS_W-1:0] l);
    return (c >= l) ? c - l : '0;
  endfunction

  function automatic logic [AXIS_W-1:0] win_hi(input logic [AXIS_W-1:0] c,
                                               input logic [AXIS_W-1:0] l,
                                               input logic [AXIS_W-1:0] nm1);
    logic [AXIS_W:0] s;
    s = {1'b0, c} + {1'b0, l};
    return (s > {1'b0, nm1}) ? nm1 : s[AXIS_W-1:0];
  endfunction

  // Window walk and read-modify-write accumulation.
  logic [AXIS_W-1:0] wi_q, wj_q, wk_q;
  logic [AXIS_W-1:0] loi, loj, lok, hii, hij, hik;
  logic signed [AXIS_W:0]     da, db, dc;
  logic signed [2*AXIS_W+1:0] qa, qb, qc;
  logic [DIST_W-1:0] wdist;
  logic              in_win, acc_last;
  logic [CNT_W+SIZE_W:0] n_acc;
  logic              acc_v_q;
  logic [CELL_W-1:0] acc_addr_q;

  assign loi = win_lo(ci_q, l_q);
  assign loj = win_lo(cj_q, l_q);
  assign lok = win_lo(ck_q, l_q);
  assign hii = win_hi(ci_q, l_q, sx_m1);
  assign hij = win_hi(cj_q, l_q, sy_m1);
  assign hik = win_hi(ck_q, l_q, sz_m1);

  assign da = $signed({1'b0, ci_q}) - $signed({1'b0, wi_q});
  assign db = $signed({1'b0, cj_q}) - $signed({1'b0, wj_q});
  assign dc = $signed({1'b0, ck_q}) - $signed({1'b0, wk_q});
  assign qa = da * da;
  assign qb = db * db;
  assign qc = dc * dc;
  assign wdist  = DIST_W'(qa[2*AXIS_W-1:0]) + DIST_W'(qb[2*AXIS_W-1:0])
                + DIST_W'(qc[2*AXIS_W-1:0]);
  assign in_win = wdist <= rad2;
  assign acc_last = wi_q == hii && wj_q == hij && wk_q == hik;
  assign n_acc = (CNT_W+SIZE_W+1)'(wi_q) + (CNT_W+SIZE_W+1)'(wj_q * sx)
               + (CNT_W+SIZE_W+1)'(wk_q * sxy);

  always_ff @(posedge clk_i) begin
    if (cmd_i.lcalc_en) begin
      wi_q <= loi;
      wj_q <= loj;
      wk_q <= lok;
    end else if (cmd_i.acc_en) begin
      if (wk_q != hik) begin
        wk_q <= wk_q + 1'b1;
      end else begin
        wk_q <= lok;
        if (wj_q != hij) begin
          wj_q <= wj_q + 1'b1;
        end else begin
          wj_q <= loj;
          wi_q <= wi_q + 1'b1;
        end
      end
    end
    acc_addr_q <= n_acc[CELL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_v_q <= 1'b0;
    end else begin
      acc_v_q <= cmd_i.acc_en && in_win;
    end
  end

  // Grid memory: value sum above hit count.
  logic [CELL_W-1:0] clr_q;
  logic [CELL_W-1:0] rd_idx_q;
  logic              grid_we;
  logic [CELL_W-1:0] grid_waddr, grid_raddr;
  logic [GRID_W-1:0] grid_wdata, grid_rdata;
  logic signed [SUM_W-1:0] gsum;
  logic [CNT_W-1:0]  gcnt;

  assign gsum = $signed(grid_rdata[GRID_W-1:CNT_W]);
  assign gcnt = grid_rdata[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= cmd_i.clr_en ? clr_q + 1'b1 : '0;
    end
  end

  assign grid_we    = cmd_i.clr_en || acc_v_q;
  assign grid_waddr = cmd_i.clr_en ? clr_q : acc_addr_q;
  assign grid_wdata = cmd_i.clr_en ? '0
                    : {gsum + SUM_W'(f_q), gcnt + 1'b1};
  assign grid_raddr = cmd_i.acc_en ? n_acc[CELL_W-1:0] : rd_idx_q;

  dsi_ram #(.WIDTH(GRID_W), .DEPTH(CELLS)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .raddr_i (grid_raddr),
    .rdata_o (grid_rdata)
  );

  // Cell read and division.
  logic             res_read_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q, cnt_eff;
  logic             div_busy;
  logic [SUM_W-1:0] quo, sum_mag, q_signed;

  assign cnt_eff = ({1'b0, rd_idx_q} < n_cells) ? gcnt : '0;
  assign sum_mag = gsum[SUM_W-1] ? SUM_W'(-gsum) : SUM_W'(gsum);

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      rd_idx_q   <= cell_index_i;
      res_read_q <= kind_i == KIND_READ;
    end
    if (cmd_i.rd_cap) begin
      cnt_q <= cnt_eff;
      neg_q <= gsum[SUM_W-1];
    end
  end

  dsi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.rd_cap),
    .dividend_i (sum_mag),
    .divisor_i  (gcnt),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign q_signed = neg_q ? -quo : quo;

  // Result register.
  logic                    out_valid_q;
  logic                    res_kind_q;
  logic signed [VAL_W-1:0] res_value_q;
  logic [CNT_W-1:0]        res_cnt_q;
  logic [NODE_CW-1:0]      res_nodes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_load) begin
      res_kind_q  <= res_read_q ? RES_READ : RES_RUN;
      res_value_q <= (res_read_q && cnt_q != '0) ? $signed(q_signed[VAL_W-1:0]) : '0;
      res_cnt_q   <= res_read_q ? cnt_q : '0;
      res_nodes_q <= tot_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = res_kind_q;
  assign cell_value_o        = res_value_q;
  assign contributor_count_o = res_cnt_q;
  assign nodes_used_o        = res_nodes_q;

  always_comb begin
    sts_o            = '0;
    sts_o.clr_done   = clr_q == '1;
    sts_o.total_zero = tot_q == '0;
    sts_o.srch_done  = m_q == tot_q && !sv_q;
    sts_o.l_done     = !grow;
    sts_o.acc_last   = acc_last;
    sts_o.cell_last  = cell_last;
    sts_o.div_busy   = div_busy;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for discrete_sibson_interpolator_top: random and directed node, run and
// read words checked against a behavioral Sibson predictor held in a scoreboard class.
// Depends on dsi_pkg, dsi_if and the RTL under src.
`timescale 1ns / 1ps

module tb_top;
  import dsi_pkg::*;

  localparam logic [1:0]           KIND_NONE = 2'd3;  // unused code, the block drops it
  localparam logic [CFG_IDX_W-1:0] REG_NONE  = 2'd3;  // index past the three size registers
  localparam int                   LIMIT     = 4_000_000;
  localparam int                   DRAIN     = 80;    // pause after a drain, long enough for a read

  typedef struct {
    logic [1:0]         kind;
    logic               first_node;
    logic [7:0]         node_x;
    logic [7:0]         node_y;
    logic [7:0]         node_z;
    logic signed [31:0] node_value;
    logic [11:0]        cell_index;
  } in_word_t;

  typedef struct {
    logic               result_kind;
    logic signed [31:0] cell_value;
    logic [12:0]        contributor_count;
    logic [8:0]         nodes_used;
  } res_word_t;

  // Behavioral model of the interpolator plus the queue of results it predicts.
  class sibson_scoreboard;
    logic [SIZE_W-1:0] size_reg[3];
    int                node_cnt;
    int                nx[MAX_NODES], ny[MAX_NODES], nz[MAX_NODES];
    longint            nv[MAX_NODES];
    longint            cell_sum[CELLS];
    int                cell_hits[CELLS];
    res_word_t         pending_results[$];
    int                errors;

    function new();
      size_reg = '{5'd16, 5'd16, 5'd16};
      node_cnt = 0;
      errors   = 0;
      foreach (cell_sum[n]) begin
        cell_sum[n]  = 0;
        cell_hits[n] = 0;
      end
    endfunction

    function int cells_on(int axis);
      if (size_reg[axis] == 0) return 1;
      if (size_reg[axis] > MAX_AXIS) return MAX_AXIS;
      return int'(size_reg[axis]);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      if (idx == REG_GRID_X) size_reg[0] = data;
      else if (idx == REG_GRID_Y) size_reg[1] = data;
      else if (idx == REG_GRID_Z) size_reg[2] = data;
    endfunction

    // Nearest node per cell, then spread its value over the clipped sphere of that radius.
    function void sweep();
      int     sx, sy, sz, l, n;
      longint best, t, dx, dy, dz, f, a, b, c;
      sx = cells_on(0);
      sy = cells_on(1);
      sz = cells_on(2);
      foreach (cell_sum[q]) begin
        cell_sum[q]  = 0;
        cell_hits[q] = 0;
      end
      if (node_cnt == 0) return;
      for (int gk = 0; gk < sz; gk++)
        for (int gj = 0; gj < sy; gj++)
          for (int gi = 0; gi < sx; gi++) begin
            best = 0;
            f    = 0;
            for (int m = 0; m < node_cnt; m++) begin
              dx = gi * 16 - nx[m];
              dy = gj * 16 - ny[m];
              dz = gk * 16 - nz[m];
              t  = dx * dx + dy * dy + dz * dz;
              if (m == 0 || t < best) begin
                best = t;
                f    = nv[m];
              end
            end
            l = 0;
            while (longint'(l + 1) * (l + 1) * 256 <= best && l < 2 * MAX_AXIS) l++;
            for (int i = (gi - l < 0 ? 0 : gi - l); i <= (gi + l > sx - 1 ? sx - 1 : gi + l); i++)
              for (int j = (gj - l < 0 ? 0 : gj - l); j <= (gj + l > sy - 1 ? sy - 1 : gj + l); j++)
                for (int k = (gk - l < 0 ? 0 : gk - l); k <= (gk + l > sz - 1 ? sz - 1 : gk + l);
                     k++) begin
                  a = gi - i;
                  b = gj - j;
                  c = gk - k;
                  if (best >= 256 * (a * a + b * b + c * c)) begin
                    n = i + j * sx + k * sx * sy;
                    cell_sum[n]  += f;
                    cell_hits[n] += 1;
                  end
                end
          end
    endfunction

    function void note_input(in_word_t w);
      res_word_t r;
      int        total_cells, idx;
      longint    q;
      r.nodes_used = 9'(node_cnt);
      if (w.kind == KIND_LOAD) begin
        if (w.first_node) node_cnt = 0;
        if (node_cnt < MAX_NODES) begin
          nx[node_cnt] = w.node_x;
          ny[node_cnt] = w.node_y;
          nz[node_cnt] = w.node_z;
          nv[node_cnt] = longint'(w.node_value);
          node_cnt++;
        end
      end else if (w.kind == KIND_RUN) begin
        sweep();
        r.result_kind       = RES_RUN;
        r.cell_value        = '0;
        r.contributor_count = '0;
        pending_results.push_back(r);
      end else if (w.kind == KIND_READ) begin
        total_cells = cells_on(0) * cells_on(1) * cells_on(2);
        idx = w.cell_index;
        q   = 0;
        r.contributor_count = '0;
        if (idx < total_cells) begin
          r.contributor_count = 13'(cell_hits[idx]);
          if (cell_hits[idx] != 0) q = cell_sum[idx] / longint'(cell_hits[idx]);
        end
        r.result_kind = RES_READ;
        r.cell_value  = q[31:0];
        pending_results.push_back(r);
      end
    endfunction

    function void check_result(res_word_t got);
      res_word_t want;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: kind %0d value %0d", got.result_kind,
               got.cell_value);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
        errors++;
      end
      if (got.cell_value !== want.cell_value) begin
        $error("cell_value: expected %0d, got %0d", want.cell_value, got.cell_value);
        errors++;
      end
      if (got.contributor_count !== want.contributor_count) begin
        $error("contributor_count: expected %0d, got %0d", want.contributor_count,
               got.contributor_count);
        errors++;
      end
      if (got.nodes_used !== want.nodes_used) begin
        $error("nodes_used: expected %0d, got %0d", want.nodes_used, got.nodes_used);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SIZE_W-1:0]    cfg_data_i;

  dsi_in_if  in_ch ();
  dsi_out_if out_ch ();

  discrete_sibson_interpolator_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  sibson_scoreboard sb = new();

  int   cycle_cnt = 0;
  int   words_sent = 0;
  int   stall_left = 0;
  logic calm = 1'b0;

  always #5 clk_i = ~clk_i;

  // Cycle counter and watchdog. The calm flag gives stretches where neither side idles.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    calm      <= (cycle_cnt[9:7] == 3'd0);
    if (cycle_cnt > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check any word that moved at this edge, then pick the next ready value.
  // Mostly ready is drawn at random; now and then the receiver holds off for a long stretch.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.result_kind, out_ch.cell_value, out_ch.contributor_count,
                        out_ch.nodes_used});
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(99) < 3) begin
      stall_left   <= $urandom_range(40, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) < 75);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 65) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Presents one word after a random gap and holds it until the block takes it. The valid
  // line is only lowered when a gap follows, so it never sees two updates in one step.
  task automatic send_word(in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= w.kind;
    in_ch.first_node <= w.first_node;
    in_ch.node_x     <= w.node_x;
    in_ch.node_y     <= w.node_y;
    in_ch.node_z     <= w.node_z;
    in_ch.node_value <= w.node_value;
    in_ch.cell_index <= w.cell_index;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(w);
    if (w.kind != KIND_NONE) words_sent++;
  endtask

  task automatic send_load(logic first, logic [7:0] x, logic [7:0] y, logic [7:0] z,
                           logic signed [31:0] v);
    send_word('{KIND_LOAD, first, x, y, z, v, 12'($urandom)});
  endtask

  task automatic send_run();
    send_word('{KIND_RUN, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                32'($urandom), 12'($urandom)});
  endtask

  task automatic send_read(logic [11:0] idx);
    send_word('{KIND_READ, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                32'($urandom), idx});
  endtask

  // Waits until every predicted result has come back, then lets a read's worth of cycles
  // pass so a trailing load is surely finished before the sizes change.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_grid(logic [SIZE_W-1:0] gx, logic [SIZE_W-1:0] gy, logic [SIZE_W-1:0] gz,
                          bit poke_spare);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [SIZE_W-1:0]    val[4];
    idx = '{REG_GRID_X, REG_GRID_Y, REG_GRID_Z, REG_NONE};
    val = '{gx, gy, gz, 5'($urandom)};
    for (int r = 0; r < (poke_spare ? 4 : 3); r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[r];
      cfg_data_i <= val[r];
      @(posedge clk_i);
      sb.write_reg(idx[r], val[r]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One random scene: pick a grid, load a node list, run, and read cells back. Reads before
  // the run see the old sums under the new sizes. Big grids get dense, shallow node sets so
  // the sweep windows stay small.
  task automatic random_scene(bit fill_store);
    int sizes[9][3] = '{'{4, 4, 1}, '{3, 5, 1}, '{1, 1, 1}, '{0, 31, 1}, '{16, 16, 1},
                        '{1, 1, 16}, '{2, 3, 4}, '{16, 1, 1}, '{5, 5, 2}};
    int pick, gx, gy, gz, cells, nodes, zmax, reads;
    bit fresh;
    pick = fill_store ? 2 : $urandom_range(8);
    set_grid(sizes[pick][0], sizes[pick][1], sizes[pick][2], $urandom_range(3) == 0);
    gx = sb.cells_on(0);
    gy = sb.cells_on(1);
    gz = sb.cells_on(2);
    cells = gx * gy * gz;
    if (fill_store) nodes = $urandom_range(262, 257);
    else if (cells > 32) nodes = $urandom_range(48, 24);
    else nodes = $urandom_range(8, 1);
    zmax  = (cells > 32) ? 16 * gz : 255;
    fresh = fill_store || cells > 32 || sb.node_cnt > 16 || $urandom_range(4) != 0;
    for (int r = 0; r < $urandom_range(2); r++) send_read(12'($urandom_range(cells - 1)));
    for (int n = 0; n < nodes; n++) begin
      if ($urandom_range(19) == 0) send_word('{KIND_NONE, 1'($urandom), 8'($urandom),
                                                8'($urandom), 8'($urandom), 32'($urandom),
                                                12'($urandom)});
      send_load((n == 0 && fresh) || (cells <= 32 && $urandom_range(39) == 0),
                8'($urandom), 8'($urandom), 8'($urandom_range(zmax)), 32'($urandom));
    end
    send_run();
    reads = $urandom_range(cells < 20 ? cells + 2 : 20, 3);
    for (int r = 0; r < reads; r++) begin
      if ($urandom_range(4) == 0) send_read(12'($urandom));
      else send_read(12'($urandom_range(cells - 1)));
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_GRID_X;
    cfg_data_i        = '0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_LOAD;
    in_ch.first_node  = 1'b0;
    in_ch.node_x      = '0;
    in_ch.node_y      = '0;
    in_ch.node_z      = '0;
    in_ch.node_value  = '0;
    in_ch.cell_index  = '0;
    out_ch.ready      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset sizes (the full cube): reads before any run, a run with no nodes, and reads of
    // the last cell and of cell 1234 afterwards. All of them must come back zero.
    send_read(12'd0);
    send_read(12'd4095);
    send_run();
    send_read(12'd4095);
    send_read(12'd1234);
    wait_drained();

    // Small 2x2 grid: coordinate and value extremes, a tie at the same spot (the earlier
    // node must win), an unused kind, an out-of-range read, then an appended node.
    set_grid(5'd2, 5'd2, 5'd1, 1'b1);
    send_load(1'b1, 8'd0, 8'd0, 8'd0, 32'sh7fffffff);
    send_load(1'b0, 8'd255, 8'd255, 8'd255, 32'sh80000000);
    send_load(1'b0, 8'd16, 8'd0, 8'd0, -32'sd1);
    send_load(1'b0, 8'd16, 8'd0, 8'd0, 32'sd12345);
    send_run();
    for (int c = 0; c < 4; c++) send_read(12'(c));
    send_read(12'd4);
    send_word('{KIND_NONE, 1'b1, 8'd1, 8'd2, 8'd3, 32'sd7, 12'd0});
    send_read(12'd3);
    send_load(1'b0, 8'd8, 8'd24, 8'd0, 32'sh00010000);
    send_run();
    send_read(12'd2);
    send_read(12'd0);
    wait_drained();

    // Random scenes. The store is overfilled now and then, so loads past the last entry get
    // dropped; every scene change is a full drain, which also pauses the sender.
    for (int scene = 0; words_sent < 1050; scene++) begin
      random_scene(scene == 3 || $urandom_range(40) == 0);
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
